// File: rtl/core/ssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared widths and the per-request context record of the swept circle test.
// ----------------------------------------------------------------------------
package ssc_pkg;

	localparam int IN_W   = 256;
	localparam int OUT_W  = 96;
	localparam int USER_W = 1;

	typedef struct packed {
		logic               dx_neg;
		logic               dy_neg;
		logic [31:0]        mdx;
		logic [31:0]        mdy;
		logic signed [32:0] abx;
		logic signed [32:0] aby;
		logic [31:0]        rsum;
		logic [65:0]        absq;
		logic [63:0]        r2;
		logic [64:0]        dot;
		logic               dot_ok;
		logic [32:0]        len;
		logic               ok;
		logic [33:0]        ae;
		logic               af_neg;
		logic [33:0]        maf;
		logic [31:0]        ox;
		logic [31:0]        oy;
		logic               fx_neg;
		logic               fy_neg;
		logic [36:0]        mfx;
		logic [36:0]        mfy;
		logic               fz;
	} ctx_t;

endpackage

// File: rtl/core/ssc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_mul
// Two-stage unsigned multiplier lanes built from four half-width products.
// ----------------------------------------------------------------------------
module ssc_mul #(
	parameter int W  = 33,
	parameter int NP = 1,
	parameter int SW = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_i,
	input  logic [NP-1:0][W-1:0]       a,
	input  logic [NP-1:0][W-1:0]       b,
	input  logic [SW-1:0]              side_i,
	output logic                       vld_o,
	output logic [NP-1:0][2*W-1:0]     p,
	output logic [SW-1:0]              side_o
);
	localparam int H  = (W + 1) / 2;
	localparam int HW = W - H;

	logic [NP-1:0][2*H-1:0]    ll_s1;
	logic [NP-1:0][H+HW-1:0]   lh_s1;
	logic [NP-1:0][H+HW-1:0]   hl_s1;
	logic [NP-1:0][2*HW-1:0]   hh_s1;
	logic [SW-1:0]             side_s1;
	logic [SW-1:0]             side_s2;
	logic [NP-1:0][2*W-1:0]    p_s2;
	logic                      vld_s1;
	logic                      vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	for (genvar g = 0; g < NP; g++) begin : g_lane
		always_ff @(posedge clk) begin
			if (en) begin
				ll_s1[g] <= a[g][H-1:0] * b[g][H-1:0];
				lh_s1[g] <= a[g][H-1:0] * b[g][W-1:H];
				hl_s1[g] <= a[g][W-1:H] * b[g][H-1:0];
				hh_s1[g] <= a[g][W-1:H] * b[g][W-1:H];
				p_s2[g]  <= (2*W)'(ll_s1[g]) + ((2*W)'(lh_s1[g]) << H)
					+ ((2*W)'(hl_s1[g]) << H) + ((2*W)'(hh_s1[g]) << (2*H));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_i;
			side_s2 <= side_s1;
		end
	end

	assign vld_o  = vld_s2;
	assign p      = p_s2;
	assign side_o = side_s2;

endmodule

// File: rtl/core/ssc_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_sqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module ssc_sqrt #(
	parameter int N  = 64,
	parameter int NL = 1,
	parameter int SW = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vld_i,
	input  logic [NL-1:0][N-1:0]     rad,
	input  logic [SW-1:0]            side_i,
	output logic                     vld_o,
	output logic [NL-1:0][N/2-1:0]   root,
	output logic [SW-1:0]            side_o
);
	localparam int M = N / 2;

	logic [NL-1:0][N-1:0]   rad_s  [0:M];
	logic [NL-1:0][M+1:0]   rem_s  [0:M];
	logic [NL-1:0][M-1:0]   root_s [0:M];
	logic [SW-1:0]          side_s [0:M];
	logic                   vld_s  [0:M];

	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_i;
	assign vld_s[0]  = vld_i;

	for (genvar k = 0; k < M; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
			end
		end

		for (genvar g = 0; g < NL; g++) begin : g_lane
			logic [M+3:0] t;
			logic [M+3:0] trial;
			logic         take;

			assign t     = {rem_s[k][g], rad_s[k][g][N-1:N-2]};
			assign trial = {2'b00, root_s[k][g], 2'b01};
			assign take  = t >= trial;

			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[k+1][g]  <= {rad_s[k][g][N-3:0], 2'b00};
					rem_s[k+1][g]  <= take ? (M+2)'(t - trial) : (M+2)'(t);
					root_s[k+1][g] <= {root_s[k][g][M-2:0], take};
				end
			end
		end
	end

	assign vld_o  = vld_s[M];
	assign root   = root_s[M];
	assign side_o = side_s[M];

endmodule

// File: rtl/core/ssc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_div
// Pipelined restoring divider with a shared divisor, one quotient bit per
// register stage. The quotient must fit in Q bits.
// ----------------------------------------------------------------------------
module ssc_div #(
	parameter int N  = 66,
	parameter int W  = 33,
	parameter int Q  = 34,
	parameter int NL = 1,
	parameter int SW = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vld_i,
	input  logic [NL-1:0][N-1:0]     num,
	input  logic [W-1:0]             den,
	input  logic [SW-1:0]            side_i,
	output logic                     vld_o,
	output logic [NL-1:0][Q-1:0]     quo,
	output logic [SW-1:0]            side_o
);
	logic [NL-1:0][Q-1:0]   num_s [0:Q];
	logic [NL-1:0][W-1:0]   rem_s [0:Q];
	logic [NL-1:0][Q-1:0]   quo_s [0:Q];
	logic [W-1:0]           den_s [0:Q];
	logic [SW-1:0]          side_s [0:Q];
	logic                   vld_s  [0:Q];

	for (genvar g = 0; g < NL; g++) begin : g_init
		assign num_s[0][g] = num[g][Q-1:0];
		assign rem_s[0][g] = W'(num[g] >> Q);
	end
	assign quo_s[0]  = '0;
	assign den_s[0]  = den;
	assign side_s[0] = side_i;
	assign vld_s[0]  = vld_i;

	for (genvar k = 0; k < Q; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				den_s[k+1]  <= den_s[k];
			end
		end

		for (genvar g = 0; g < NL; g++) begin : g_lane
			logic [W:0] t;
			logic       take;

			assign t    = {rem_s[k][g], num_s[k][g][Q-1]};
			assign take = t >= {1'b0, den_s[k]};

			always_ff @(posedge clk) begin
				if (en) begin
					num_s[k+1][g] <= {num_s[k][g][Q-2:0], 1'b0};
					rem_s[k+1][g] <= take ? W'(t - {1'b0, den_s[k]}) : W'(t);
					quo_s[k+1][g] <= {quo_s[k][g][Q-2:0], take};
				end
			end
		end
	end

	assign vld_o  = vld_s[Q];
	assign quo    = quo_s[Q];
	assign side_o = side_s[Q];

endmodule

// File: rtl/core/swept_circle_circle_collision_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_circle_circle_collision_unit
// Swept circle against fixed circle contact test in fixed point, fully
// pipelined through multipliers, square roots and dividers.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Content
//  s_*     | in        | s_tvalid/s_tready  | one circle pair and its move
//  m_*     | out       | m_tvalid/m_tready  | hit flag, contact move, normal
//
//  A new request is taken every cycle while no result waits; its result is
//  offered after passing through 206 register stages.
//  Most of the depth comes from the chain of three square roots and three
//  dividers, each producing one result bit per stage.
//  The whole pipeline advances together; it holds when a result waits.
//  Reset clears only the valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module swept_circle_circle_collision_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// mover_x, mover_y, mover_radius, target_x, target_y, target_radius,
	// move_dx, move_dy, two zero bits
	input  logic [ssc_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// contact_dx, contact_dy, normal_x, normal_y
	output logic [ssc_pkg::OUT_W-1:0]   m_tdata,
	// hit
	output logic [ssc_pkg::USER_W-1:0]  m_tuser
);
	localparam int CW = $bits(ssc_pkg::ctx_t);

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Input split and first register stage.
	logic signed [31:0] mx, my, tx, ty, dx, dy;
	logic [30:0]        ra, rb;
	assign mx = s_tdata[31:0];
	assign my = s_tdata[63:32];
	assign ra = s_tdata[94:64];
	assign tx = s_tdata[126:95];
	assign ty = s_tdata[158:127];
	assign rb = s_tdata[189:159];
	assign dx = s_tdata[221:190];
	assign dy = s_tdata[253:222];

	ssc_pkg::ctx_t c0, c1_s1;
	logic          vld_s1;

	always_comb begin
		c0        = '0;
		c0.dx_neg = dx[31];
		c0.dy_neg = dy[31];
		c0.mdx    = dx[31] ? 32'(-dx) : dx;
		c0.mdy    = dy[31] ? 32'(-dy) : dy;
		c0.abx    = {tx[31], tx} - {mx[31], mx};
		c0.aby    = {ty[31], ty} - {my[31], my};
		c0.rsum   = {1'b0, ra} + {1'b0, rb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c1_s1 <= c0;
		end
	end

	// Squares and dot product terms.
	logic [32:0] mabx, maby;
	assign mabx = c1_s1.abx[32] ? 33'(-c1_s1.abx) : c1_s1.abx;
	assign maby = c1_s1.aby[32] ? 33'(-c1_s1.aby) : c1_s1.aby;

	logic [6:0][32:0] m1_a, m1_b;
	logic [6:0][65:0] m1_p;
	logic [CW-1:0]    m1_side;
	logic             m1_vld;

	assign m1_a = {{1'b0, c1_s1.rsum}, {1'b0, c1_s1.mdy}, {1'b0, c1_s1.mdx}, maby, mabx,
		{1'b0, c1_s1.mdy}, {1'b0, c1_s1.mdx}};
	assign m1_b = {{1'b0, c1_s1.rsum}, maby, mabx, maby, mabx,
		{1'b0, c1_s1.mdy}, {1'b0, c1_s1.mdx}};

	ssc_mul #(.W(33), .NP(7), .SW(CW)) u_mul1 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s1),
		.a(m1_a), .b(m1_b), .side_i(c1_s1),
		.vld_o(m1_vld), .p(m1_p), .side_o(m1_side)
	);

	ssc_pkg::ctx_t c1m, c2c, c2_s2;
	logic [65:0]   pos, neg, lsq, lsq_s2;
	logic          vld_s2;

	always_comb begin
		c1m        = ssc_pkg::ctx_t'(m1_side);
		lsq        = m1_p[0] + m1_p[1];
		pos        = ((c1m.dx_neg ^ c1m.abx[32]) ? 66'd0 : m1_p[4])
			+ ((c1m.dy_neg ^ c1m.aby[32]) ? 66'd0 : m1_p[5]);
		neg        = ((c1m.dx_neg ^ c1m.abx[32]) ? m1_p[4] : 66'd0)
			+ ((c1m.dy_neg ^ c1m.aby[32]) ? m1_p[5] : 66'd0);
		c2c        = c1m;
		c2c.absq   = m1_p[2] + m1_p[3];
		c2c.r2     = m1_p[6][63:0];
		c2c.dot_ok = neg < pos;
		c2c.dot    = 65'(pos - neg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= m1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c2_s2  <= c2c;
			lsq_s2 <= lsq;
		end
	end

	// Move length and center distance.
	logic [1:0][65:0] q1_rad;
	logic [1:0][32:0] q1_root;
	logic [CW-1:0]    q1_side;
	logic             q1_vld;

	assign q1_rad = {c2_s2.absq, lsq_s2};

	ssc_sqrt #(.N(66), .NL(2), .SW(CW)) u_sqrt1 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s2),
		.rad(q1_rad), .side_i(c2_s2),
		.vld_o(q1_vld), .root(q1_root), .side_o(q1_side)
	);

	ssc_pkg::ctx_t c3c, c3_s3;
	logic          vld_s3;

	always_comb begin
		c3c     = ssc_pkg::ctx_t'(q1_side);
		c3c.len = q1_root[0];
		c3c.ok  = c3c.dot_ok && (q1_root[0] != 33'd0)
			&& ({1'b0, q1_root[0]} + {2'b00, c3c.rsum} > {1'b0, q1_root[1]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= q1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c3_s3 <= c3c;
		end
	end

	// Projection of the center offset on the move direction.
	logic [0:0][65:0] d1_num;
	logic [0:0][33:0] d1_quo;
	logic [CW-1:0]    d1_side;
	logic             d1_vld;

	assign d1_num[0] = {1'b0, c3_s3.dot};

	ssc_div #(.N(66), .W(33), .Q(34), .NL(1), .SW(CW)) u_div1 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s3),
		.num(d1_num), .den(c3_s3.len), .side_i(c3_s3),
		.vld_o(d1_vld), .quo(d1_quo), .side_o(d1_side)
	);

	ssc_pkg::ctx_t c4c, c4_s4;
	logic          vld_s4;

	always_comb begin
		c4c    = ssc_pkg::ctx_t'(d1_side);
		c4c.ae = d1_quo[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c4_s4 <= c4c;
		end
	end

	logic [0:0][33:0] m2_a;
	logic [0:0][67:0] m2_p;
	logic [CW-1:0]    m2_side;
	logic             m2_vld;

	assign m2_a[0] = c4_s4.ae;

	ssc_mul #(.W(34), .NP(1), .SW(CW)) u_mul2 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s4),
		.a(m2_a), .b(m2_a), .side_i(c4_s4),
		.vld_o(m2_vld), .p(m2_p), .side_o(m2_side)
	);

	ssc_pkg::ctx_t c5c, c5_s5;
	logic [65:0]   be2;
	logic [63:0]   diff, diff_s5;
	logic          vld_s5;

	always_comb begin
		c5c    = ssc_pkg::ctx_t'(m2_side);
		be2    = ({2'b00, c5c.absq} < m2_p[0]) ? 66'd0 : 66'({2'b00, c5c.absq} - m2_p[0]);
		diff   = 64'({2'b00, c5c.r2} - be2);
		c5c.ok = c5c.ok && (be2 < {2'b00, c5c.r2});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= m2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c5_s5   <= c5c;
			diff_s5 <= diff;
		end
	end

	// Distance from the projection back to the contact point.
	logic [0:0][63:0] q2_rad;
	logic [0:0][31:0] q2_root;
	logic [CW-1:0]    q2_side;
	logic             q2_vld;

	assign q2_rad[0] = diff_s5;

	ssc_sqrt #(.N(64), .NL(1), .SW(CW)) u_sqrt2 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s5),
		.rad(q2_rad), .side_i(c5_s5),
		.vld_o(q2_vld), .root(q2_root), .side_o(q2_side)
	);

	ssc_pkg::ctx_t      c6c, c6_s6;
	logic signed [34:0] af;
	logic               vld_s6;

	always_comb begin
		c6c        = ssc_pkg::ctx_t'(q2_side);
		af         = {1'b0, c6c.ae} - {3'b000, q2_root[0]};
		c6c.af_neg = af[34];
		c6c.maf    = af[34] ? 34'(-af) : af[33:0];
		c6c.ok     = c6c.ok && (af < $signed({2'b00, c6c.len}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= q2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c6_s6 <= c6c;
		end
	end

	// Move up to contact, scaled per component.
	logic [1:0][33:0] m3_a, m3_b;
	logic [1:0][67:0] m3_p;
	logic [1:0][65:0] d2_num;
	logic [1:0][35:0] d2_quo;
	logic [CW-1:0]    m3_side, d2_side;
	logic             m3_vld, d2_vld;
	ssc_pkg::ctx_t    c6m;

	assign m3_a = {{2'b00, c6_s6.mdy}, {2'b00, c6_s6.mdx}};
	assign m3_b = {c6_s6.maf, c6_s6.maf};

	ssc_mul #(.W(34), .NP(2), .SW(CW)) u_mul3 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s6),
		.a(m3_a), .b(m3_b), .side_i(c6_s6),
		.vld_o(m3_vld), .p(m3_p), .side_o(m3_side)
	);

	assign c6m    = ssc_pkg::ctx_t'(m3_side);
	assign d2_num = {m3_p[1][65:0], m3_p[0][65:0]};

	ssc_div #(.N(66), .W(33), .Q(36), .NL(2), .SW(CW)) u_div2 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(m3_vld),
		.num(d2_num), .den(c6m.len), .side_i(m3_side),
		.vld_o(d2_vld), .quo(d2_quo), .side_o(d2_side)
	);

	ssc_pkg::ctx_t      c7c, c7_s7;
	logic signed [36:0] cx, cy;
	logic signed [37:0] fbx, fby;
	logic               vld_s7;

	always_comb begin
		c7c        = ssc_pkg::ctx_t'(d2_side);
		cx         = (c7c.dx_neg ^ c7c.af_neg) ? 37'(37'd0 - {1'b0, d2_quo[0]})
			: {1'b0, d2_quo[0]};
		cy         = (c7c.dy_neg ^ c7c.af_neg) ? 37'(37'd0 - {1'b0, d2_quo[1]})
			: {1'b0, d2_quo[1]};
		fbx        = {cx[36], cx} - {{5{c7c.abx[32]}}, c7c.abx};
		fby        = {cy[36], cy} - {{5{c7c.aby[32]}}, c7c.aby};
		c7c.fx_neg = fbx[37];
		c7c.fy_neg = fby[37];
		c7c.mfx    = fbx[37] ? 37'(-fbx) : fbx[36:0];
		c7c.mfy    = fby[37] ? 37'(-fby) : fby[36:0];
		c7c.ox     = (cx > 37'sd2147483647) ? 32'h7fff_ffff
			: ((cx < -37'sd2147483648) ? 32'h8000_0000 : cx[31:0]);
		c7c.oy     = (cy > 37'sd2147483647) ? 32'h7fff_ffff
			: ((cy < -37'sd2147483648) ? 32'h8000_0000 : cy[31:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c7_s7 <= c7c;
		end
	end

	// Length of the target-to-contact vector.
	logic [1:0][36:0] m4_a;
	logic [1:0][73:0] m4_p;
	logic [CW-1:0]    m4_side;
	logic             m4_vld;

	assign m4_a = {c7_s7.mfy, c7_s7.mfx};

	ssc_mul #(.W(37), .NP(2), .SW(CW)) u_mul4 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s7),
		.a(m4_a), .b(m4_a), .side_i(c7_s7),
		.vld_o(m4_vld), .p(m4_p), .side_o(m4_side)
	);

	ssc_pkg::ctx_t c8_s8;
	logic [75:0]   fsq_s8;
	logic          vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= m4_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c8_s8  <= ssc_pkg::ctx_t'(m4_side);
			fsq_s8 <= {2'b00, m4_p[0]} + {2'b00, m4_p[1]};
		end
	end

	logic [0:0][75:0] q3_rad;
	logic [0:0][37:0] q3_root;
	logic [CW-1:0]    q3_side;
	logic             q3_vld;
	ssc_pkg::ctx_t    c9;

	assign q3_rad[0] = fsq_s8;

	ssc_sqrt #(.N(76), .NL(1), .SW(CW)) u_sqrt3 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s8),
		.rad(q3_rad), .side_i(c8_s8),
		.vld_o(q3_vld), .root(q3_root), .side_o(q3_side)
	);

	always_comb begin
		c9    = ssc_pkg::ctx_t'(q3_side);
		c9.fz = q3_root[0] == 38'd0;
	end

	// Unit normal in Q1.15.
	logic [1:0][51:0] d3_num;
	logic [1:0][15:0] d3_quo;
	logic [CW-1:0]    d3_side;
	logic             d3_vld;

	assign d3_num = {{c9.mfy, 15'd0}, {c9.mfx, 15'd0}};

	ssc_div #(.N(52), .W(38), .Q(16), .NL(2), .SW(CW)) u_div3 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(q3_vld),
		.num(d3_num), .den(q3_root[0]), .side_i(c9),
		.vld_o(d3_vld), .quo(d3_quo), .side_o(d3_side)
	);

	ssc_pkg::ctx_t cf;
	logic [15:0]   nx, ny;
	logic [95:0]   data_c;

	always_comb begin
		cf = ssc_pkg::ctx_t'(d3_side);
		if (cf.fx_neg) begin
			nx = (d3_quo[0] > 16'd32768) ? 16'h8000 : 16'(17'd0 - {1'b0, d3_quo[0]});
		end else begin
			nx = (d3_quo[0] > 16'd32767) ? 16'h7fff : d3_quo[0];
		end
		if (cf.fy_neg) begin
			ny = (d3_quo[1] > 16'd32768) ? 16'h8000 : 16'(17'd0 - {1'b0, d3_quo[1]});
		end else begin
			ny = (d3_quo[1] > 16'd32767) ? 16'h7fff : d3_quo[1];
		end
		if (cf.fz) begin
			nx = 16'd0;
			ny = 16'd0;
		end
		data_c = cf.ok ? {ny, nx, cf.oy, cf.ox} : 96'd0;
	end

	logic                        m_tvalid_q;
	logic [ssc_pkg::OUT_W-1:0]   m_tdata_q;
	logic [ssc_pkg::USER_W-1:0]  m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= d3_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= data_c;
			m_tuser_q <= cf.ok;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: rtl/core/ssc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks on the swept circle collision unit.
// ----------------------------------------------------------------------------
module ssc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [ssc_pkg::OUT_W-1:0]   m_tdata,
	input logic [ssc_pkg::USER_W-1:0]  m_tuser
);
	// A result without a hit carries no contact or normal.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("miss result carries nonzero data");

	// The input side only stalls while a result waits.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

	// A request that is held off always faces a stalled output.
	a_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && !s_tready) |-> !m_tready)
		else $error("input stalled while output was free");

endmodule

bind swept_circle_circle_collision_unit ssc_checker u_ssc_checker (.*);
